// ===== src/crg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package crg_pkg;

    // Field and datapath widths
    localparam int SCR_W      = 16;   // Q8.8 screen coordinate
    localparam int AXIS_W     = 16;   // one lane of a packed vector
    localparam int LANES      = 3;    // x, y, z
    localparam int OUT_W      = 24;   // Q16.8 end point lane
    localparam int SQ_W       = 32;   // squared screen term / squared plane distance
    localparam int DIST_W     = 16;   // plane distance and distortion
    localparam int RAD_W      = 40;   // Q16.24 depth squared when not negative
    localparam int ROOT_W     = RAD_W / 2;
    localparam int PROD_W     = SQ_W + DIST_W;
    localparam int DIFF_W     = PROD_W + 1;
    localparam int FWD_W      = AXIS_W + ROOT_W + 1;
    localparam int XPROD_W    = AXIS_W + SCR_W;
    localparam int ACC_W      = 40;   // sum with 26 fraction bits
    localparam int POS_SHIFT  = 18;
    localparam int XY_SHIFT   = 4;
    localparam int FRAC_SHIFT = 18;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAMERA_POSITION = 3'd0,
        CFG_FORWARD_AXIS    = 3'd1,
        CFG_UP_AXIS         = 3'd2,
        CFG_RIGHT_AXIS      = 3'd3,
        CFG_PLANE_DISTANCE  = 3'd4,
        CFG_DISTORTION      = 3'd5
    } crg_cfg_idx_t;

    // Register reset values
    localparam logic [47:0] CAMERA_POSITION_RST = 48'd0;
    localparam logic [47:0] FORWARD_AXIS_RST    = 48'd16384;
    localparam logic [47:0] UP_AXIS_RST         = 48'd1073741824;
    localparam logic [31:0] RIGHT_AXIS_RST      = 32'd16384;
    localparam logic [15:0] PLANE_DISTANCE_RST  = 16'd256;
    localparam logic [15:0] DISTORTION_RST      = 16'd256;

    // Payload carried alongside the square root pipeline
    typedef struct packed {
        logic                    neg;
        logic signed [SCR_W-1:0] sx;
        logic signed [SCR_W-1:0] sy;
    } crg_side_t;

    localparam int SIDE_W = $bits(crg_side_t);

    // Round half up to Q16.8 and saturate to the output range
    function automatic logic [OUT_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] biased;
        logic signed [ACC_W-1:0] q;
        logic signed [ACC_W-1:0] q_max;
        logic signed [ACC_W-1:0] q_min;
        biased = acc + (ACC_W'(1) <<< (FRAC_SHIFT - 1));
        q      = biased >>> FRAC_SHIFT;
        q_max  = (ACC_W'(1) <<< (OUT_W - 1)) - ACC_W'(1);
        q_min  = -(ACC_W'(1) <<< (OUT_W - 1));
        if (q > q_max)
        begin
            return q_max[OUT_W-1:0];
        end
        else if (q < q_min)
        begin
            return q_min[OUT_W-1:0];
        end
        return q[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/crg_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Screen coordinate channel
interface crg_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [crg_pkg::SCR_W-1:0] screen_x;
    logic signed [crg_pkg::SCR_W-1:0] screen_y;

    modport source (output valid, output screen_x, output screen_y, input ready);
    modport sink   (input valid, input screen_x, input screen_y, output ready);
endinterface

`default_nettype wire

// ===== src/crg_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Ray end point channel
interface crg_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [crg_pkg::OUT_W-1:0] end_x;
    logic signed [crg_pkg::OUT_W-1:0] end_y;
    logic signed [crg_pkg::OUT_W-1:0] end_z;
    logic                             ray_valid;

    modport source (output valid, output end_x, output end_y, output end_z,
                    output ray_valid, input ready);
    modport sink   (input valid, input end_x, input end_y, input end_z,
                    input ray_valid, output ready);
endinterface

`default_nettype wire

// ===== src/camera_ray_endpoint_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Payload                          | Handshake
// screen   | in  | screen_x, screen_y (Q8.8)        | valid/ready
// ray      | out | end_x, end_y, end_z (Q16.8), ray_valid | valid/ready
// cfg      | in  | cfg_index, cfg_wdata             | cfg_wr_en, no back-pressure
//
// One transaction per clock sustained while ray accepts; the path from accept to ray.valid runs through
// 5 front stages, 20 square root stages at one root bit each, 3 product and sum stages and the output register.
// Reset clears all stage valid bits (ray_valid is not reset) and loads the register defaults.
// A stall on ray freezes the whole pipeline; screen.ready drops only while the
// output register holds a transaction that is not taken.
module camera_ray_endpoint_generator (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [crg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [crg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    crg_in_if.sink                               screen,
    crg_out_if.source                            ray
);

    localparam int SCR_W   = crg_pkg::SCR_W;
    localparam int AXIS_W  = crg_pkg::AXIS_W;
    localparam int LANES   = crg_pkg::LANES;
    localparam int OUT_W   = crg_pkg::OUT_W;
    localparam int SQ_W    = crg_pkg::SQ_W;
    localparam int DIST_W  = crg_pkg::DIST_W;
    localparam int RAD_W   = crg_pkg::RAD_W;
    localparam int ROOT_W  = crg_pkg::ROOT_W;
    localparam int PROD_W  = crg_pkg::PROD_W;
    localparam int DIFF_W  = crg_pkg::DIFF_W;
    localparam int FWD_W   = crg_pkg::FWD_W;
    localparam int XPROD_W = crg_pkg::XPROD_W;
    localparam int ACC_W   = crg_pkg::ACC_W;

    // Configuration registers
    logic [3*AXIS_W-1:0] camera_position_reg;
    logic [3*AXIS_W-1:0] forward_axis_reg;
    logic [3*AXIS_W-1:0] up_axis_reg;
    logic [2*AXIS_W-1:0] right_axis_reg;
    logic [DIST_W-1:0]   plane_distance_reg;
    logic [DIST_W-1:0]   distortion_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            camera_position_reg <= crg_pkg::CAMERA_POSITION_RST;
            forward_axis_reg    <= crg_pkg::FORWARD_AXIS_RST;
            up_axis_reg         <= crg_pkg::UP_AXIS_RST;
            right_axis_reg      <= crg_pkg::RIGHT_AXIS_RST;
            plane_distance_reg  <= crg_pkg::PLANE_DISTANCE_RST;
            distortion_reg      <= crg_pkg::DISTORTION_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                crg_pkg::CFG_CAMERA_POSITION: camera_position_reg <= cfg_wdata[3*AXIS_W-1:0];
                crg_pkg::CFG_FORWARD_AXIS:    forward_axis_reg    <= cfg_wdata[3*AXIS_W-1:0];
                crg_pkg::CFG_UP_AXIS:         up_axis_reg         <= cfg_wdata[3*AXIS_W-1:0];
                crg_pkg::CFG_RIGHT_AXIS:      right_axis_reg      <= cfg_wdata[2*AXIS_W-1:0];
                crg_pkg::CFG_PLANE_DISTANCE:  plane_distance_reg  <= cfg_wdata[DIST_W-1:0];
                crg_pkg::CFG_DISTORTION:      distortion_reg      <= cfg_wdata[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // Lane views of the packed vectors
    logic signed [AXIS_W-1:0] pos_lane [LANES];
    logic signed [AXIS_W-1:0] fwd_lane [LANES];
    logic signed [AXIS_W-1:0] up_lane  [LANES];

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            pos_lane[k] = camera_position_reg[AXIS_W*k +: AXIS_W];
            fwd_lane[k] = forward_axis_reg[AXIS_W*k +: AXIS_W];
            up_lane[k]  = up_axis_reg[AXIS_W*k +: AXIS_W];
        end
    end

    logic signed [AXIS_W-1:0] right_x;
    logic signed [AXIS_W-1:0] right_z;
    assign right_x = right_axis_reg[AXIS_W-1:0];
    assign right_z = right_axis_reg[2*AXIS_W-1:AXIS_W];

    // Global advance: the pipeline moves unless the output holds an untaken result
    logic adv;
    logic out_vld_reg;
    assign adv          = !out_vld_reg || ray.ready;
    assign screen.ready = adv;

    // Valid bits of the front and back stages
    logic a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg, e_vld_reg;
    logic f_vld_reg, g_vld_reg, h_vld_reg;
    logic sq_vld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            d_vld_reg   <= 1'b0;
            e_vld_reg   <= 1'b0;
            f_vld_reg   <= 1'b0;
            g_vld_reg   <= 1'b0;
            h_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg   <= screen.valid;
            b_vld_reg   <= a_vld_reg;
            c_vld_reg   <= b_vld_reg;
            d_vld_reg   <= c_vld_reg;
            e_vld_reg   <= d_vld_reg;
            f_vld_reg   <= sq_vld;
            g_vld_reg   <= f_vld_reg;
            h_vld_reg   <= g_vld_reg;
            out_vld_reg <= h_vld_reg;
        end
    end

    // Stage A: input capture
    logic signed [SCR_W-1:0] a_sx_reg, a_sy_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_sx_reg <= screen.screen_x;
            a_sy_reg <= screen.screen_y;
        end
    end

    // Stage B: squares
    logic signed [SCR_W-1:0] b_sx_reg, b_sy_reg;
    logic [SQ_W-1:0]         b_sx2_reg, b_sy2_reg, b_pd2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_sx_reg  <= a_sx_reg;
            b_sy_reg  <= a_sy_reg;
            b_sx2_reg <= SQ_W'(a_sx_reg * a_sx_reg);
            b_sy2_reg <= SQ_W'(a_sy_reg * a_sy_reg);
            b_pd2_reg <= SQ_W'(plane_distance_reg * plane_distance_reg);
        end
    end

    // Stage C: radius squared and scaled plane distance squared
    logic signed [SCR_W-1:0] c_sx_reg, c_sy_reg;
    logic [SQ_W-1:0]         c_r2_reg;
    logic [RAD_W-1:0]        c_pd2s_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_sx_reg   <= b_sx_reg;
            c_sy_reg   <= b_sy_reg;
            c_r2_reg   <= b_sx2_reg + b_sy2_reg;
            c_pd2s_reg <= {b_pd2_reg, 8'h00};
        end
    end

    // Stage D: distortion product
    logic signed [SCR_W-1:0] d_sx_reg, d_sy_reg;
    logic [PROD_W-1:0]       d_r2dw_reg;
    logic [RAD_W-1:0]        d_pd2s_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_sx_reg   <= c_sx_reg;
            d_sy_reg   <= c_sy_reg;
            d_r2dw_reg <= PROD_W'(c_r2_reg * distortion_reg);
            d_pd2s_reg <= c_pd2s_reg;
        end
    end

    // Stage E: depth squared and its sign
    logic [DIFF_W-1:0] d2_diff;
    assign d2_diff = DIFF_W'(d_pd2s_reg) - DIFF_W'(d_r2dw_reg);

    logic [RAD_W-1:0]    e_rad_reg;
    crg_pkg::crg_side_t  e_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_side_reg.neg <= d2_diff[DIFF_W-1];
            e_side_reg.sx  <= d_sx_reg;
            e_side_reg.sy  <= d_sy_reg;
            e_rad_reg      <= d2_diff[DIFF_W-1] ? '0 : d2_diff[RAD_W-1:0];
        end
    end

    // Square root pipeline
    logic [ROOT_W-1:0]   sq_root;
    crg_pkg::crg_side_t  sq_side;

    crg_isqrt #(
        .ROOT_W (ROOT_W),
        .SIDE_W (crg_pkg::SIDE_W)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (e_vld_reg),
        .rad      (e_rad_reg),
        .in_side  (e_side_reg),
        .out_vld  (sq_vld),
        .root     (sq_root),
        .out_side (sq_side)
    );

    // Stage F: axis products
    logic signed [ROOT_W:0]    depth_s;
    assign depth_s = {1'b0, sq_root};

    logic signed [FWD_W-1:0]   f_fwd_reg [LANES];
    logic signed [XPROD_W-1:0] f_up_reg  [LANES];
    logic signed [XPROD_W-1:0] f_rx_reg, f_rz_reg;
    logic                      f_neg_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                f_fwd_reg[k] <= FWD_W'(fwd_lane[k] * depth_s);
                f_up_reg[k]  <= XPROD_W'(up_lane[k] * sq_side.sy);
            end
            f_rx_reg  <= XPROD_W'(right_x * sq_side.sx);
            f_rz_reg  <= XPROD_W'(right_z * sq_side.sx);
            f_neg_reg <= sq_side.neg;
        end
    end

    // Stage G: partial sums
    logic signed [XPROD_W-1:0] f_right [LANES];
    assign f_right[0] = f_rx_reg;
    assign f_right[1] = '0;
    assign f_right[2] = f_rz_reg;

    logic signed [ACC_W-1:0] g_a_reg [LANES];
    logic signed [ACC_W-1:0] g_b_reg [LANES];
    logic                    g_neg_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                g_a_reg[k] <= (ACC_W'(pos_lane[k]) <<< crg_pkg::POS_SHIFT) + ACC_W'(f_fwd_reg[k]);
                g_b_reg[k] <= (ACC_W'(f_right[k]) + ACC_W'(f_up_reg[k])) <<< crg_pkg::XY_SHIFT;
            end
            g_neg_reg <= f_neg_reg;
        end
    end

    // Stage H: full sum
    logic signed [ACC_W-1:0] h_acc_reg [LANES];
    logic                    h_neg_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                h_acc_reg[k] <= g_a_reg[k] + g_b_reg[k];
            end
            h_neg_reg <= g_neg_reg;
        end
    end

    // Output register: round, saturate, or fall back to the camera position
    logic [OUT_W-1:0] end_next [LANES];
    logic [OUT_W-1:0] end_reg  [LANES];
    logic             ray_valid_reg;

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            if (h_neg_reg)
            begin
                end_next[k] = OUT_W'(pos_lane[k]);
            end
            else
            begin
                end_next[k] = crg_pkg::round_sat(h_acc_reg[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                end_reg[k] <= end_next[k];
            end
            ray_valid_reg <= !h_neg_reg;
        end
    end

    assign ray.valid     = out_vld_reg;
    assign ray.end_x     = end_reg[0];
    assign ray.end_y     = end_reg[1];
    assign ray.end_z     = end_reg[2];
    assign ray.ray_valid = ray_valid_reg;

endmodule

`default_nettype wire

// ===== src/crg_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pipelined integer square root, one result bit per stage
module crg_isqrt #(
    parameter int ROOT_W = crg_pkg::ROOT_W,
    parameter int SIDE_W = crg_pkg::SIDE_W
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_vld,
    input  wire logic [2*ROOT_W-1:0]   rad,
    input  wire logic [SIDE_W-1:0]     in_side,
    output logic                       out_vld,
    output logic [ROOT_W-1:0]          root,
    output logic [SIDE_W-1:0]          out_side
);

    localparam int RAD_W = 2 * ROOT_W;

    logic              vld_reg  [ROOT_W];
    logic [RAD_W:0]    rem_reg  [ROOT_W];
    logic [RAD_W:0]    res_reg  [ROOT_W];
    logic [SIDE_W-1:0] side_reg [ROOT_W];

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_step
        localparam logic [RAD_W:0] STEP_BIT = {{RAD_W{1'b0}}, 1'b1} << (2 * (ROOT_W - 1 - i));

        logic              vld_in;
        logic [RAD_W:0]    rem_in;
        logic [RAD_W:0]    res_in;
        logic [SIDE_W-1:0] side_in;
        logic [RAD_W:0]    trial;

        if (i == 0)
        begin : g_first
            assign vld_in  = in_vld;
            assign rem_in  = {1'b0, rad};
            assign res_in  = '0;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign vld_in  = vld_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign res_in  = res_reg[i-1];
            assign side_in = side_reg[i-1];
        end

        assign trial = res_in + STEP_BIT;

        // valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= vld_in;
            end
        end

        // restoring step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[i] <= side_in;
                if (rem_in >= trial)
                begin
                    rem_reg[i] <= rem_in - trial;
                    res_reg[i] <= (res_in >> 1) + STEP_BIT;
                end
                else
                begin
                    rem_reg[i] <= rem_in;
                    res_reg[i] <= res_in >> 1;
                end
            end
        end
    end

    assign out_vld  = vld_reg[ROOT_W-1];
    assign root     = res_reg[ROOT_W-1][ROOT_W-1:0];
    assign out_side = side_reg[ROOT_W-1];

endmodule

`default_nettype wire
